@@ rtl/trf_pkg.sv @@
// ----------------------------------------------------------------------------
// trf_pkg
// Shared types and constants for the text restriction filter: beat
// layouts, pattern special characters, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

  localparam int PATTERN_DEPTH_DEF = 64;

  localparam int CP_W       = 21;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 16;
  localparam int PLEN_W     = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CP_W-1:0] CH_CARET  = 21'h00005E;
  localparam logic [CP_W-1:0] CH_DASH   = 21'h00002D;
  localparam logic [CP_W-1:0] CH_BSLASH = 21'h00005C;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 4'd1;

  typedef struct packed {
    logic            func;
    logic [IDX_W-1:0] pattern_index;
    logic [CP_W-1:0] code_point;
    logic            is_last;
  } trf_in_t;

  typedef struct packed {
    logic [CP_W-1:0] out_char;
    logic            keep;
    logic            out_last;
  } trf_out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    logic [CP_W-1:0]  data;
  } trf_pat_wr_t;

  typedef struct packed {
    logic            start;
    logic [CP_W-1:0] code_point;
  } trf_walk_req_t;

  typedef struct packed {
    logic done;
    logic allowed;
  } trf_walk_rsp_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_WALK,
    T_EMIT
  } trf_top_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_RUN,
    W_END
  } trf_walk_state_t;

  // Parser position inside one pattern token.
  typedef enum logic [2:0] {
    P_TOK,
    P_ESC1,
    P_HAVE1,
    P_RANGE,
    P_ESC2
  } trf_parse_state_t;

endpackage

`default_nettype wire

@@ rtl/trf_walker.sv @@
// ----------------------------------------------------------------------------
// trf_walker
// Holds the pattern store and walks it one entry per cycle, parsing carets,
// escapes and ranges on the fly and matching each token against the code
// point with a single shared compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_walker #(
  parameter int PATTERN_DEPTH = trf_pkg::PATTERN_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire trf_pkg::trf_pat_wr_t        wr,
  input  wire logic [trf_pkg::PLEN_W-1:0]  pattern_length,
  input  wire trf_pkg::trf_walk_req_t      req,
  output trf_pkg::trf_walk_rsp_t           rsp
);

  localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int CW = $clog2(PATTERN_DEPTH + 1);
  localparam int LW = (CW > trf_pkg::PLEN_W) ? CW : trf_pkg::PLEN_W;
  localparam int IW = (CW > trf_pkg::IDX_W) ? CW : trf_pkg::IDX_W;

  logic [trf_pkg::CP_W-1:0] mem [PATTERN_DEPTH];

  trf_pkg::trf_walk_state_t  wstate, wstate_next;
  trf_pkg::trf_parse_state_t pstate, pstate_next;

  logic [CW-1:0]            pos, pos_next;
  logic                     rd_vld;
  logic                     rd_last;
  logic                     rd_first;
  logic [trf_pkg::CP_W-1:0] rd_data;
  logic [trf_pkg::CP_W-1:0] first, first_next;
  logic                     in_allow, in_allow_next;
  logic                     allowed, allowed_next;
  logic                     done, done_next;

  logic [LW-1:0]            len_ext;
  logic [LW-1:0]            len_clamped;
  logic [CW-1:0]            len;
  logic                     issue;
  logic                     wr_in_range;

  // Shared compare unit.
  logic                     m_en;
  logic [trf_pkg::CP_W-1:0] m_lo;
  logic [trf_pkg::CP_W-1:0] m_hi;
  logic                     hit;

  assign len_ext     = LW'(pattern_length);
  assign len_clamped = (len_ext > LW'(PATTERN_DEPTH)) ? LW'(PATTERN_DEPTH) : len_ext;
  assign len         = len_clamped[CW-1:0];
  assign issue       = (wstate == trf_pkg::W_RUN) && (pos < len);
  assign wr_in_range = IW'(wr.index) < IW'(PATTERN_DEPTH);

  // A range end of zero means the token matches its start exactly.
  assign hit = (m_hi != '0) ? ((req.code_point >= m_lo) && (req.code_point <= m_hi))
                            : (req.code_point == m_lo);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[AW'(wr.index)] <= wr.data;
    end
    if (issue) begin
      rd_data <= mem[pos[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wstate <= trf_pkg::W_IDLE;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      wstate <= wstate_next;
      rd_vld <= issue;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pstate   <= pstate_next;
    pos      <= pos_next;
    first    <= first_next;
    in_allow <= in_allow_next;
    allowed  <= allowed_next;
    if (issue) begin
      rd_last  <= (pos == len - CW'(1));
      rd_first <= (pos == '0);
    end
  end

  always_comb begin
    wstate_next   = wstate;
    pstate_next   = pstate;
    pos_next      = pos;
    first_next    = first;
    in_allow_next = in_allow;
    allowed_next  = allowed;
    done_next     = 1'b0;
    m_en          = 1'b0;
    m_lo          = first;
    m_hi          = '0;

    unique case (wstate)
      trf_pkg::W_IDLE: begin
        if (req.start) begin
          if (len == '0) begin
            allowed_next = 1'b1;
            done_next    = 1'b1;
          end else begin
            wstate_next   = trf_pkg::W_RUN;
            pos_next      = '0;
            pstate_next   = trf_pkg::P_TOK;
            in_allow_next = 1'b1;
          end
        end
      end

      trf_pkg::W_RUN: begin
        if (issue) begin
          pos_next = pos + CW'(1);
        end
        if (rd_vld) begin
          if (rd_first) begin
            allowed_next = (rd_data == trf_pkg::CH_CARET);
          end
          unique case (pstate)
            trf_pkg::P_TOK, trf_pkg::P_HAVE1: begin
              if ((pstate == trf_pkg::P_HAVE1) && (rd_data == trf_pkg::CH_DASH)) begin
                pstate_next = trf_pkg::P_RANGE;
              end else begin
                // A pending single character closes before the new token opens.
                m_en = (pstate == trf_pkg::P_HAVE1);
                if (rd_data == trf_pkg::CH_CARET) begin
                  in_allow_next = !in_allow;
                  pstate_next   = trf_pkg::P_TOK;
                end else if (rd_data == trf_pkg::CH_BSLASH) begin
                  pstate_next = trf_pkg::P_ESC1;
                end else begin
                  first_next  = rd_data;
                  pstate_next = trf_pkg::P_HAVE1;
                end
              end
            end
            trf_pkg::P_ESC1: begin
              first_next  = rd_data;
              pstate_next = trf_pkg::P_HAVE1;
            end
            trf_pkg::P_RANGE: begin
              if (rd_data == trf_pkg::CH_BSLASH) begin
                pstate_next = trf_pkg::P_ESC2;
              end else begin
                m_en        = 1'b1;
                m_hi        = rd_data;
                pstate_next = trf_pkg::P_TOK;
              end
            end
            trf_pkg::P_ESC2: begin
              m_en        = 1'b1;
              m_hi        = rd_data;
              pstate_next = trf_pkg::P_TOK;
            end
            default: begin
              pstate_next = trf_pkg::P_TOK;
            end
          endcase
          if (rd_last) begin
            wstate_next = trf_pkg::W_END;
          end
        end
      end

      trf_pkg::W_END: begin
        // Close whatever token the pattern ended inside; missing codes read as zero.
        unique case (pstate)
          trf_pkg::P_TOK: begin
            m_en = 1'b0;
          end
          trf_pkg::P_ESC1: begin
            m_en = 1'b1;
            m_lo = '0;
          end
          default: begin
            m_en = 1'b1;
          end
        endcase
        done_next   = 1'b1;
        wstate_next = trf_pkg::W_IDLE;
      end

      default: begin
        wstate_next = trf_pkg::W_IDLE;
      end
    endcase

    if (m_en && hit) begin
      allowed_next = in_allow;
    end
  end

  assign rsp.done    = done;
  assign rsp.allowed = allowed;

endmodule

`default_nettype wire

@@ rtl/text_restrict_filter_core.sv @@
// Sequencing: a text beat starts a walk reading L entries of the single-port store,
// one per cycle, L being the pattern length clamped to the store depth; an empty
// pattern needs no walk. The keep flag is registered when the walk is done and the
// result beat once the output is free; only then is a new beat taken.
// Reset: synchronous; clears both registers, the character count and all handshakes.
// The pattern store is not cleared and must be written before it is walked.
// ----------------------------------------------------------------------------
// text_restrict_filter_core
// Filters code points against a restriction pattern and truncates strings
// to a maximum kept length; one result beat per text beat.
// ----------------------------------------------------------------------------
`default_nettype none

module text_restrict_filter_core #(
  parameter int PATTERN_DEPTH = trf_pkg::PATTERN_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire trf_pkg::trf_in_t                item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output trf_pkg::trf_out_t                    result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [trf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [trf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  trf_pkg::trf_top_state_t state, state_next;

  logic [trf_pkg::CNT_W-1:0]  max_chars;
  logic [trf_pkg::PLEN_W-1:0] pattern_length;
  logic [trf_pkg::CNT_W-1:0]  char_count;

  logic [trf_pkg::CP_W-1:0]   cur_cp;
  logic                       cur_last;
  logic                       cur_within;
  logic                       keep_hold;

  logic                       text_accept;
  logic                       in_limit;
  logic                       load_keep;
  logic                       load_result;

  trf_pkg::trf_pat_wr_t       wr;
  trf_pkg::trf_walk_req_t     req;
  trf_pkg::trf_walk_rsp_t     rsp;

  assign cfg_ready   = 1'b1;
  assign item_ready  = (state == trf_pkg::T_IDLE);
  assign text_accept = item_valid && item_ready && (item.func == trf_pkg::FUNC_TEXT);
  assign in_limit    = (max_chars == '0) || (char_count < max_chars);

  assign wr.en    = item_valid && item_ready && (item.func == trf_pkg::FUNC_PATTERN);
  assign wr.index = item.pattern_index;
  assign wr.data  = item.code_point;

  assign req.start      = text_accept;
  assign req.code_point = cur_cp;

  trf_walker #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .pattern_length(pattern_length),
    .req           (req),
    .rsp           (rsp)
  );

  always_comb begin
    state_next  = state;
    load_keep   = 1'b0;
    load_result = 1'b0;
    unique case (state)
      trf_pkg::T_IDLE: begin
        if (text_accept) begin
          state_next = trf_pkg::T_WALK;
        end
      end
      trf_pkg::T_WALK: begin
        if (rsp.done) begin
          load_keep  = 1'b1;
          state_next = trf_pkg::T_EMIT;
        end
      end
      trf_pkg::T_EMIT: begin
        // The output register frees up in the same cycle its beat is taken.
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = trf_pkg::T_IDLE;
        end
      end
      default: begin
        state_next = trf_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= trf_pkg::T_IDLE;
      max_chars      <= '0;
      pattern_length <= '0;
      char_count     <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == trf_pkg::CFG_MAX_CHARS) begin
          max_chars <= cfg_data;
        end else if (cfg_index == trf_pkg::CFG_PATTERN_LENGTH) begin
          pattern_length <= cfg_data[trf_pkg::PLEN_W-1:0];
        end
      end
      if (text_accept) begin
        if (item.is_last) begin
          char_count <= '0;
        end else if (char_count != trf_pkg::CNT_MAX) begin
          char_count <= char_count + trf_pkg::CNT_W'(1);
        end
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_accept) begin
      cur_cp     <= item.code_point;
      cur_last   <= item.is_last;
      cur_within <= in_limit;
    end
    if (load_keep) begin
      keep_hold <= cur_within && rsp.allowed;
    end
    if (load_result) begin
      result.out_char <= cur_cp;
      result.keep     <= keep_hold;
      result.out_last <= cur_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/trf_checker.sv @@
// ----------------------------------------------------------------------------
// trf_checker
// Port-level checks on the text restriction filter: reset state, the
// one-beat-at-a-time sequencing and output beat stability.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire trf_pkg::trf_in_t  item,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire trf_pkg::trf_out_t result
);

  // After reset the block is empty and ready for a beat.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!result_valid && item_ready))
    else $error("block not idle after reset");

  // A text beat occupies the sequencer, so the next cycle cannot take a beat.
  a_text_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.func == trf_pkg::FUNC_TEXT)) |=> !item_ready)
    else $error("input accepted while a text beat is being walked");

  // A pattern write leaves the block ready to take a beat in the next cycle.
  a_pattern_fast: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.func == trf_pkg::FUNC_PATTERN)) |=> item_ready)
    else $error("pattern write did not return to ready");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed or dropped");

endmodule

bind text_restrict_filter_core trf_checker u_trf_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .item        (item),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);

`default_nettype wire
